FILE: hdl/tpckv_pkg.sv
// Shared constants, codes and memory write-port types for the two-phase-commit key-value table.
// No dependencies.

package tpckv_pkg;

    // Number of table slots and the index width that follows from it.
    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 64;

    // Action codes; 4..7 are unrecognized.
    localparam logic [2:0] ACT_READ   = 3'd0;
    localparam logic [2:0] ACT_CREATE = 3'd1;
    localparam logic [2:0] ACT_UPDATE = 3'd2;
    localparam logic [2:0] ACT_DELETE = 3'd3;

    // Phase codes.
    localparam logic [1:0] PH_PREPARE  = 2'd0;
    localparam logic [1:0] PH_COMMIT   = 2'd1;
    localparam logic [1:0] PH_ROLLBACK = 2'd2;

    typedef enum logic [3:0] {
        STAT_READ_HIT      = 4'd0,
        STAT_NOT_FOUND     = 4'd1,
        STAT_ALREADY_PREP  = 4'd2,
        STAT_PREPARE_OK    = 4'd3,
        STAT_PREPARE_FAIL  = 4'd4,
        STAT_NOT_PREPARED  = 4'd5,
        STAT_WRITTEN       = 4'd6,
        STAT_DELETED       = 4'd7,
        STAT_INVALID_OP    = 4'd8,
        STAT_ROLLED_BACK   = 4'd9,
        STAT_INVALID_PHASE = 4'd10,
        STAT_TABLE_FULL    = 4'd11
    } status_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [KEY_W-1:0] data;
    } key_wr_t;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        logic [VALUE_W-1:0] data;
    } val_wr_t;

endpackage

FILE: hdl/tpckv_key_mem.sv
// Slot key memory: one write port, one read port, registered read data.
// Depends on tpckv_pkg.

module tpckv_key_mem (
    input  logic                    clk,
    input  logic                    rd_en,
    input  logic [tpckv_pkg::IDX_W-1:0] rd_addr,
    output logic [tpckv_pkg::KEY_W-1:0] rd_data,
    input  tpckv_pkg::key_wr_t      wr
);
    import tpckv_pkg::*;

    logic [KEY_W-1:0] mem [TABLE_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/tpckv_val_mem.sv
// Slot value memory: one write port, one read port, registered read data.
// Depends on tpckv_pkg.

module tpckv_val_mem (
    input  logic                          clk,
    input  logic                          rd_en,
    input  logic [tpckv_pkg::IDX_W-1:0]   rd_addr,
    output logic [tpckv_pkg::VALUE_W-1:0] rd_data,
    input  tpckv_pkg::val_wr_t            wr
);
    import tpckv_pkg::*;

    logic [VALUE_W-1:0] mem [TABLE_ENTRIES];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/two_phase_commit_kv_table_core.sv
// Top level of the two-phase-commit participant key-value table: sequencer, slot flags, outputs.
// Depends on tpckv_pkg, tpckv_key_mem and tpckv_val_mem.

// Each item is accepted when start is high while busy is low, and its single result appears
// on success/status/resp_value for exactly one cycle with done high; busy drops in that same
// cycle and the next item can be accepted at the edge that ends it, so no new item is taken
// while one is still in flight. The time taken is set by the key search: the key memory has
// one read port and is scanned one slot per cycle, and its read data is registered; after the
// last slot come a value-memory read state (S_VREAD) and a decide/write-back state (S_RESP).
// The receiver cannot stall; done is a one-cycle strobe and must be captured when seen.
// The present and prepared flags of every slot sit in flip-flops cleared by reset, so the
// block is usable right after reset with no clearing pass; data read from the key and value
// memories is never used for a slot that is not in use.

module two_phase_commit_kv_table_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         action,
    input  logic [1:0]         phase,
    input  logic signed [31:0] req_key,
    input  logic [63:0]        req_value,
    output logic               done,
    output logic               success,
    output logic [3:0]         status,
    output logic [63:0]        resp_value
);
    import tpckv_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_VREAD = 4'b0100,
        S_RESP  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // Latched request
    logic [2:0]         action_reg;
    logic [1:0]         phase_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;

    // Scan pipeline: issue index, then compare in the next cycle
    logic [IDX_W-1:0] scan_idx_reg, scan_idx_next;
    logic             issue_done_reg, issue_done_next;
    logic             rd_vld_reg, rd_vld_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;

    // Search results
    logic             hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic             free_reg, free_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;

    // Slot flags
    logic [TABLE_ENTRIES-1:0] present_reg, present_next;
    logic [TABLE_ENTRIES-1:0] prepared_reg, prepared_next;

    // Result registers
    logic               done_reg, done_next;
    logic               success_reg, success_next;
    logic [3:0]         status_reg, status_next;
    logic [VALUE_W-1:0] resp_value_reg, resp_value_next;

    // Memory ports
    logic               key_rd_en;
    logic [KEY_W-1:0]   key_rdata;
    key_wr_t            key_wr;
    logic               val_rd_en;
    logic [VALUE_W-1:0] val_rdata;
    val_wr_t            val_wr;

    logic in_use;
    logic is_present;
    logic is_marked;
    logic can_prep;
    logic accept;

    assign accept = start && (state_reg == S_IDLE);

    tpckv_key_mem u_key_mem (
        .clk     (clk),
        .rd_en   (key_rd_en),
        .rd_addr (scan_idx_reg),
        .rd_data (key_rdata),
        .wr      (key_wr)
    );

    tpckv_val_mem u_val_mem (
        .clk     (clk),
        .rd_en   (val_rd_en),
        .rd_addr (hit_idx_reg),
        .rd_data (val_rdata),
        .wr      (val_wr)
    );

    // Request capture; payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            phase_reg  <= phase;
            key_reg    <= req_key;
            value_reg  <= req_value;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        scan_idx_next   = scan_idx_reg;
        issue_done_next = issue_done_reg;
        rd_vld_next     = 1'b0;
        rd_idx_next     = rd_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        free_next       = free_reg;
        free_idx_next   = free_idx_reg;
        present_next    = present_reg;
        prepared_next   = prepared_reg;
        done_next       = 1'b0;
        success_next    = success_reg;
        status_next     = status_reg;
        resp_value_next = resp_value_reg;
        key_rd_en       = 1'b0;
        val_rd_en       = 1'b0;
        key_wr          = '0;
        val_wr          = '0;

        in_use     = present_reg[rd_idx_reg] | prepared_reg[rd_idx_reg];
        is_present = hit_reg & present_reg[hit_idx_reg];
        is_marked  = hit_reg & prepared_reg[hit_idx_reg];
        can_prep   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next      = S_SCAN;
                    scan_idx_next   = '0;
                    issue_done_next = 1'b0;
                    hit_next        = 1'b0;
                    free_next       = 1'b0;
                end
            end

            S_SCAN:
            begin
                // Issue one key read per cycle
                key_rd_en   = !issue_done_reg;
                rd_vld_next = !issue_done_reg;
                rd_idx_next = scan_idx_reg;
                if (!issue_done_reg)
                begin
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        scan_idx_next = scan_idx_reg + 1'b1;
                    end
                end

                // Compare the key that came back; track first match and lowest free slot
                if (rd_vld_reg)
                begin
                    if (in_use && (key_rdata == key_reg) && !hit_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = rd_idx_reg;
                    end
                    if (!in_use && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = rd_idx_reg;
                    end
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        state_next = S_VREAD;
                    end
                end
            end

            S_VREAD:
            begin
                val_rd_en  = 1'b1;
                state_next = S_RESP;
            end

            S_RESP:
            begin
                done_next       = 1'b1;
                state_next      = S_IDLE;
                success_next    = 1'b0;
                resp_value_next = '0;

                if (action_reg == ACT_READ)
                begin
                    if (is_present)
                    begin
                        success_next    = 1'b1;
                        status_next     = STAT_READ_HIT;
                        resp_value_next = val_rdata;
                    end
                    else
                    begin
                        status_next = STAT_NOT_FOUND;
                    end
                end
                else
                begin
                    case (phase_reg)
                        PH_PREPARE:
                        begin
                            if (action_reg == ACT_CREATE)
                            begin
                                can_prep = !is_present;
                            end
                            else if (action_reg == ACT_UPDATE || action_reg == ACT_DELETE)
                            begin
                                can_prep = is_present;
                            end

                            if (is_marked)
                            begin
                                status_next = STAT_ALREADY_PREP;
                            end
                            else if (!can_prep)
                            begin
                                status_next = STAT_PREPARE_FAIL;
                            end
                            else if (!hit_reg)
                            begin
                                if (!free_reg)
                                begin
                                    status_next = STAT_TABLE_FULL;
                                end
                                else
                                begin
                                    // Claim the lowest free slot for this key
                                    key_wr.en   = 1'b1;
                                    key_wr.addr = free_idx_reg;
                                    key_wr.data = key_reg;
                                    present_next[free_idx_reg]  = 1'b0;
                                    prepared_next[free_idx_reg] = 1'b1;
                                    success_next = 1'b1;
                                    status_next  = STAT_PREPARE_OK;
                                end
                            end
                            else
                            begin
                                prepared_next[hit_idx_reg] = 1'b1;
                                success_next = 1'b1;
                                status_next  = STAT_PREPARE_OK;
                            end
                        end

                        PH_COMMIT:
                        begin
                            if (!is_marked)
                            begin
                                status_next = STAT_NOT_PREPARED;
                            end
                            else
                            begin
                                prepared_next[hit_idx_reg] = 1'b0;
                                if (action_reg == ACT_CREATE || action_reg == ACT_UPDATE)
                                begin
                                    val_wr.en   = 1'b1;
                                    val_wr.addr = hit_idx_reg;
                                    val_wr.data = value_reg;
                                    present_next[hit_idx_reg] = 1'b1;
                                    success_next    = 1'b1;
                                    status_next     = STAT_WRITTEN;
                                    resp_value_next = value_reg;
                                end
                                else if (action_reg == ACT_DELETE)
                                begin
                                    present_next[hit_idx_reg] = 1'b0;
                                    success_next = 1'b1;
                                    status_next  = STAT_DELETED;
                                end
                                else
                                begin
                                    status_next = STAT_INVALID_OP;
                                end
                            end
                        end

                        PH_ROLLBACK:
                        begin
                            if (hit_reg)
                            begin
                                prepared_next[hit_idx_reg] = 1'b0;
                            end
                            status_next = STAT_ROLLED_BACK;
                        end

                        default:
                        begin
                            status_next = STAT_INVALID_PHASE;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            issue_done_reg <= 1'b0;
            rd_vld_reg     <= 1'b0;
            hit_reg        <= 1'b0;
            free_reg       <= 1'b0;
            present_reg    <= '0;
            prepared_reg   <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_done_reg <= issue_done_next;
            rd_vld_reg     <= rd_vld_next;
            hit_reg        <= hit_next;
            free_reg       <= free_next;
            present_reg    <= present_next;
            prepared_reg   <= prepared_next;
            done_reg       <= done_next;
        end
    end

    // Indexes and result payload
    always_ff @(posedge clk)
    begin
        scan_idx_reg   <= scan_idx_next;
        rd_idx_reg     <= rd_idx_next;
        hit_idx_reg    <= hit_idx_next;
        free_idx_reg   <= free_idx_next;
        success_reg    <= success_next;
        status_reg     <= status_next;
        resp_value_reg <= resp_value_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign success    = success_reg;
    assign status     = status_reg;
    assign resp_value = resp_value_reg;

endmodule
